// ----- hw/rtl/gpar_pkg.sv -----
// gpar_pkg: types and codes shared by the gpio port action block
// no dependencies; compiled first

package gpar_pkg;

  // item modes
  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_TOGGLE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_TICK   = 2'd3
  } mode_t;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_REFUSED = 2'd1,
    STATUS_DROPPED = 2'd2
  } status_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_IO_MASK_A      = 3'd0,
    REG_IO_MASK_B      = 3'd1,
    REG_IO_MASK_C      = 3'd2,
    REG_IO_MASK_D      = 3'd3,
    REG_DIGITAL_MASK_A = 3'd4,
    REG_DIGITAL_MASK_B = 3'd5,
    REG_DIGITAL_MASK_C = 3'd6,
    REG_DIGITAL_MASK_D = 3'd7
  } reg_idx_t;

  // sequencer states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_WALK = 1'b1
  } state_t;

  localparam int PORT_SLOTS = 4;

  // one revert ring entry, without its countdown
  typedef struct packed {
    logic       pending;
    logic [1:0] port;
    logic [7:0] mask;
    logic [7:0] levels;
  } rev_info_t;

  // latch update request from the revert step unit
  typedef struct packed {
    logic       apply;
    logic [1:0] port;
    logic [7:0] mask;
    logic [7:0] levels;
  } drv_req_t;

endpackage

// ----- hw/rtl/gpar_if.sv -----
// gpar_if: valid/ready channel interfaces of the gpio port action block
// input items, result items and configuration writes; no dependencies

interface gpar_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [1:0]  port;
  logic [7:0]  mask;
  logic [7:0]  value;
  logic [7:0]  seconds;
  logic [7:0]  pin_sample;
  logic [15:0] source_address;

  modport source (output valid, mode, port, mask, value, seconds, pin_sample,
                  source_address, input ready);
  modport sink   (input valid, mode, port, mask, value, seconds, pin_sample,
                  source_address, output ready);
endinterface

interface gpar_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  read_port;
  logic [7:0]  read_value;
  logic [15:0] reply_to;
  logic [7:0]  drive_a;
  logic [7:0]  drive_b;
  logic [7:0]  drive_c;
  logic [7:0]  drive_d;

  modport source (output valid, status, read_port, read_value, reply_to,
                  drive_a, drive_b, drive_c, drive_d, input ready);
  modport sink   (input valid, status, read_port, read_value, reply_to,
                  drive_a, drive_b, drive_c, drive_d, output ready);
endinterface

interface gpar_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/gpio_port_action_with_timed_revert_unit.sv -----
// gpio_port_action_with_timed_revert_unit: top level of the gpio port action block
// depends on gpar_pkg, gpar_if.sv (channel interfaces) and gpar_revert_step

// Write, toggle and read items are decided in the cycle they are accepted and
// their result item stands on the output in the next cycle; with the output taken
// at once such items go at one per cycle. A tick walks the revert ring from head
// to tail through the single ring memory, one entry per cycle; each entry of
// the ring (at most RING_DEPTH-1 of them) is read, then stepped and written
// back, and its result item stands on the output when the walk ends, after the
// last entry is written back; the block is not
// ready during the walk. Writes and toggles need every masked pin
// to be digital and an output, else status refused. A nonzero seconds field
// queues a revert of the opposite levels due after seconds*TICKS_PER_SECOND
// ticks; with the ring full the write still applies and status says dropped.
// The ring memory needs no clearing: only entries between head and tail are read.
// Configuration writes are always taken (ready tied high).

module gpio_port_action_with_timed_revert_unit #(
  parameter int PORT_COUNT       = 4,
  parameter int RING_DEPTH       = 16,
  parameter int TICKS_PER_SECOND = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  gpar_cfg_if.sink    cfg_ch,
  gpar_in_if.sink     in_ch,
  gpar_out_if.source  out_ch
);

  localparam int IDX_W  = $clog2(RING_DEPTH);
  localparam int CNT_W  = $clog2(255 * TICKS_PER_SECOND + 1);
  localparam int INFO_W = $bits(gpar_pkg::rev_info_t);
  localparam int ENT_W  = INFO_W + CNT_W;

  // ring index advance with wrap at the ring end
  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] n;
    if (i == IDX_W'(RING_DEPTH - 1)) n = '0;
    else                             n = i + IDX_W'(1);
    return n;
  endfunction

  // control state
  gpar_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [IDX_W-1:0] issue_r, issue_nxt;        // next entry to read in a walk
  logic [IDX_W-1:0] proc_idx_r, proc_idx_nxt;  // entry whose data is in rd_q
  logic             proc_v_r, proc_v_nxt;

  // port state
  logic [7:0] latch_r   [gpar_pkg::PORT_SLOTS];
  logic [7:0] latch_nxt [gpar_pkg::PORT_SLOTS];
  logic [7:0] io_mask_r  [gpar_pkg::PORT_SLOTS];
  logic [7:0] dig_mask_r [gpar_pkg::PORT_SLOTS];

  // revert ring memory: one write and one registered read a cycle
  logic [ENT_W-1:0] ring_mem [RING_DEPTH];
  logic [ENT_W-1:0] rd_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [ENT_W-1:0] mem_wdata;

  // result register
  logic                out_valid_r;
  logic                out_load;
  gpar_pkg::status_t   res_status;
  logic [1:0]          res_port;
  logic [7:0]          res_value;
  logic [15:0]         res_reply;
  logic [1:0]          out_status_r;
  logic [1:0]          out_port_r;
  logic [7:0]          out_value_r;
  logic [15:0]         out_reply_r;
  logic [7:0]          out_drive_r [gpar_pkg::PORT_SLOTS];

  // item decode
  logic                in_fire;
  gpar_pkg::mode_t     in_mode;
  logic                port_ok;
  logic                masks_ok;
  logic [7:0]          in_levels;
  logic                ring_full;
  gpar_pkg::rev_info_t new_info;
  logic [CNT_W-1:0]    new_cnt;

  // walk step
  gpar_pkg::rev_info_t rd_info;
  logic [CNT_W-1:0]    rd_cnt;
  gpar_pkg::rev_info_t step_info;
  logic [CNT_W-1:0]    step_cnt;
  logic                step_wr;
  gpar_pkg::drv_req_t  step_drv;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == gpar_pkg::S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire      = in_ch.valid && in_ch.ready;

  assign in_mode   = gpar_pkg::mode_t'(in_ch.mode);
  assign port_ok   = ({1'b0, in_ch.port} < 3'(PORT_COUNT));
  assign masks_ok  = ((dig_mask_r[in_ch.port] & in_ch.mask) == in_ch.mask) &&
                     ((io_mask_r[in_ch.port] & in_ch.mask) == in_ch.mask);
  assign in_levels = (in_mode == gpar_pkg::MODE_TOGGLE) ? ~in_ch.pin_sample : in_ch.value;
  assign ring_full = (ring_next(tail_r) == head_r);

  always_comb begin
    new_info.pending = 1'b1;
    new_info.port    = in_ch.port;
    new_info.mask    = in_ch.mask;
    new_info.levels  = ~in_levels;
  end
  assign new_cnt = CNT_W'(in_ch.seconds) * CNT_W'(TICKS_PER_SECOND);

  assign rd_info = gpar_pkg::rev_info_t'(rd_q[ENT_W-1 -: INFO_W]);
  assign rd_cnt  = rd_q[CNT_W-1:0];

  gpar_revert_step #(
    .CNT_W      (CNT_W),
    .PORT_COUNT (PORT_COUNT)
  ) u_step (
    .info_i (rd_info),
    .cnt_i  (rd_cnt),
    .info_o (step_info),
    .cnt_o  (step_cnt),
    .wr_o   (step_wr),
    .drv_o  (step_drv)
  );

  // sequencer: next state, ring writes and result selection
  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    issue_nxt    = issue_r;
    proc_idx_nxt = proc_idx_r;
    proc_v_nxt   = proc_v_r;
    latch_nxt    = latch_r;
    mem_we       = 1'b0;
    mem_waddr    = tail_r;
    mem_wdata    = {new_info, new_cnt};
    out_load     = 1'b0;
    res_status   = gpar_pkg::STATUS_DONE;
    res_port     = '0;
    res_value    = '0;
    res_reply    = '0;

    unique case (state_r)
      gpar_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_mode == gpar_pkg::MODE_TICK) begin
            state_nxt  = gpar_pkg::S_WALK;
            issue_nxt  = head_r;
            proc_v_nxt = 1'b0;
          end else if (!port_ok) begin
            res_status = gpar_pkg::STATUS_REFUSED;
            out_load   = 1'b1;
          end else if (in_mode == gpar_pkg::MODE_READ) begin
            res_port  = in_ch.port;
            res_value = in_ch.pin_sample;
            res_reply = in_ch.source_address;
            out_load  = 1'b1;
          end else if (!masks_ok) begin
            res_status = gpar_pkg::STATUS_REFUSED;
            out_load   = 1'b1;
          end else begin
            latch_nxt[in_ch.port] = (latch_r[in_ch.port] & ~in_ch.mask) |
                                    (in_levels & in_ch.mask);
            if (in_ch.seconds != 8'd0) begin
              if (ring_full) begin
                res_status = gpar_pkg::STATUS_DROPPED;
              end else begin
                mem_we   = 1'b1;
                tail_nxt = ring_next(tail_r);
              end
            end
            out_load = 1'b1;
          end
        end
      end
      gpar_pkg::S_WALK: begin
        // retire side: entry read in the previous cycle
        if (proc_v_r) begin
          mem_waddr = proc_idx_r;
          mem_wdata = {step_info, step_cnt};
          mem_we    = step_wr;
          if (step_drv.apply) begin
            latch_nxt[step_drv.port] = (latch_r[step_drv.port] & ~step_drv.mask) |
                                       (step_drv.levels & step_drv.mask);
          end
          if (!step_info.pending && (head_r == proc_idx_r)) begin
            head_nxt = ring_next(proc_idx_r);
          end
        end
        // issue side: read the next entry up to the tail
        if (issue_r != tail_r) begin
          proc_v_nxt   = 1'b1;
          proc_idx_nxt = issue_r;
          issue_nxt    = ring_next(issue_r);
        end else begin
          proc_v_nxt = 1'b0;
          if (!proc_v_r) begin
            state_nxt = gpar_pkg::S_IDLE;
            out_load  = 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= gpar_pkg::S_IDLE;
      head_r     <= '0;
      tail_r     <= '0;
      issue_r    <= '0;
      proc_idx_r <= '0;
      proc_v_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      issue_r    <= issue_nxt;
      proc_idx_r <= proc_idx_nxt;
      proc_v_r   <= proc_v_nxt;
    end
  end

  // output latches; ports beyond PORT_COUNT stay at zero
  always_ff @(posedge clk) begin
    for (int k = 0; k < gpar_pkg::PORT_SLOTS; k++) begin
      if (!rst_n || k >= PORT_COUNT) latch_r[k] <= '0;
      else                           latch_r[k] <= latch_nxt[k];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < gpar_pkg::PORT_SLOTS; k++) begin
        io_mask_r[k]  <= '0;
        dig_mask_r[k] <= '0;
      end
    end else if (cfg_ch.valid) begin
      unique case (gpar_pkg::reg_idx_t'(cfg_ch.index))
        gpar_pkg::REG_IO_MASK_A:      io_mask_r[0]  <= cfg_ch.data;
        gpar_pkg::REG_IO_MASK_B:      io_mask_r[1]  <= cfg_ch.data;
        gpar_pkg::REG_IO_MASK_C:      io_mask_r[2]  <= cfg_ch.data;
        gpar_pkg::REG_IO_MASK_D:      io_mask_r[3]  <= cfg_ch.data;
        gpar_pkg::REG_DIGITAL_MASK_A: dig_mask_r[0] <= cfg_ch.data;
        gpar_pkg::REG_DIGITAL_MASK_B: dig_mask_r[1] <= cfg_ch.data;
        gpar_pkg::REG_DIGITAL_MASK_C: dig_mask_r[2] <= cfg_ch.data;
        gpar_pkg::REG_DIGITAL_MASK_D: dig_mask_r[3] <= cfg_ch.data;
      endcase
    end
  end

  // ring memory, read address is the walk issue pointer
  always_ff @(posedge clk) begin
    if (mem_we) ring_mem[mem_waddr] <= mem_wdata;
    rd_q <= ring_mem[issue_r];
  end

  // result register, held until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status;
      out_port_r   <= res_port;
      out_value_r  <= res_value;
      out_reply_r  <= res_reply;
      out_drive_r  <= latch_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.read_port  = out_port_r;
  assign out_ch.read_value = out_value_r;
  assign out_ch.reply_to   = out_reply_r;
  assign out_ch.drive_a    = out_drive_r[0];
  assign out_ch.drive_b    = out_drive_r[1];
  assign out_ch.drive_c    = out_drive_r[2];
  assign out_ch.drive_d    = out_drive_r[3];

  // no new item while a tick walks the ring
  a_busy_walk: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gpar_pkg::S_WALK |-> !in_ch.ready)
    else $error("item accepted during ring walk");

  // the walk never processes the tail slot
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gpar_pkg::S_WALK && proc_v_r) |-> proc_idx_r != tail_r)
    else $error("ring walk ran past the tail");

  // the tail only moves on an accepted item
  a_tail_move: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r != $past(tail_r) |-> $past(in_fire))
    else $error("ring tail moved without an item");

  // a waiting result is not lost
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> out_valid_r)
    else $error("pending result dropped");

endmodule

// ----- hw/rtl/gpar_revert_step.sv -----
// gpar_revert_step: update of one revert ring entry on a tick
// depends on gpar_pkg (rev_info_t, drv_req_t)

module gpar_revert_step #(
  parameter int CNT_W      = 11,
  parameter int PORT_COUNT = 4
) (
  input  gpar_pkg::rev_info_t  info_i,
  input  logic [CNT_W-1:0]     cnt_i,
  output gpar_pkg::rev_info_t  info_o,
  output logic [CNT_W-1:0]     cnt_o,
  output logic                 wr_o,
  output gpar_pkg::drv_req_t   drv_o
);

  always_comb begin
    info_o       = info_i;
    cnt_o        = cnt_i;
    wr_o         = 1'b0;
    drv_o.apply  = 1'b0;
    drv_o.port   = info_i.port;
    drv_o.mask   = info_i.mask;
    drv_o.levels = info_i.levels;
    if (info_i.pending) begin
      wr_o = 1'b1;
      if (cnt_i != '0) begin
        cnt_o = cnt_i - CNT_W'(1);
      end else begin
        // expired: apply the revert and free the entry
        info_o.pending = 1'b0;
        drv_o.apply    = ({1'b0, info_i.port} < 3'(PORT_COUNT));
      end
    end
  end

endmodule
